[rtl/core/gevr_pkg.sv]
// Shared types and constants for the gain event timeline resolver.
package gevr_pkg;

    localparam int ACTION_W   = 2;
    localparam int STATUS_W   = 3;
    localparam int LEN_W      = 32;
    localparam int NUM_W      = 32;
    localparam int FLAG_W     = 8;
    localparam int GAIN_IN_W  = 8;
    localparam int GAIN_W     = 7;
    localparam int OFFSET_W   = 32;

    localparam logic [GAIN_IN_W-1:0] GAIN_MAX = 8'h7F;

    typedef enum logic [ACTION_W-1:0] {
        ACT_START = 2'd0,
        ACT_EVENT = 2'd1,
        ACT_END   = 2'd2
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_BAD_ARG  = 3'd1,
        ST_FLAGS    = 3'd2,
        ST_GAIN     = 3'd3,
        ST_SEQ_GAP  = 3'd4,
        ST_REGRESS  = 3'd5,
        ST_RANGE    = 3'd6
    } t_status;

endpackage

[rtl/core/gevr_in_reg.sv]
// Input register stage holding one accepted item until the core takes it.
module gevr_in_reg #(
    parameter int DATA_W = 184
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [DATA_W-1:0]             i_data,
    input  logic [gevr_pkg::ACTION_W-1:0] i_action,
    output logic                          o_valid,
    output logic [DATA_W-1:0]             o_data,
    output logic [gevr_pkg::ACTION_W-1:0] o_action,
    input  logic                          i_take
);
    import gevr_pkg::*;

    logic                r_valid;
    logic [DATA_W-1:0]   r_data;
    logic [ACTION_W-1:0] r_action;

    assign o_ready  = !r_valid || i_take;
    assign o_valid  = r_valid;
    assign o_data   = r_data;
    assign o_action = r_action;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data   <= i_data;
            r_action <= i_action;
        end
    end

endmodule

[rtl/core/gevr_core.sv]
// Frame window state, event checks, working and committed gain state.
module gevr_core #(
    parameter int SAMPLE_WIDTH      = 48,
    parameter int COUNT_WIDTH       = 48,
    parameter int EVENT_COUNT_WIDTH = 16,
    parameter int IN_W              = 184,
    parameter int OUT_W             = 200
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gevr_pkg::FLAG_W-1:0]   i_cfg_wdata,
    input  logic                          i_valid,
    input  logic [IN_W-1:0]               i_data,
    input  logic [gevr_pkg::ACTION_W-1:0] i_action,
    input  logic                          i_out_free,
    output logic                          o_take,
    output logic                          o_res_valid,
    output logic [OUT_W-1:0]              o_res_data
);
    import gevr_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = COUNT_WIDTH;
    localparam int EW  = EVENT_COUNT_WIDTH;
    localparam int LEN_LO = SW;
    localparam int NUM_LO = SW + LEN_W;
    localparam int ES_LO  = NUM_LO + NUM_W;
    localparam int FLG_LO = ES_LO + SW;
    localparam int G1_LO  = FLG_LO + FLAG_W;
    localparam int G2_LO  = G1_LO + GAIN_IN_W;
    localparam int O_SG   = STATUS_W;
    localparam int O_EG   = O_SG + GAIN_W;
    localparam int O_OFF  = O_EG + GAIN_W;
    localparam int O_SEEN = O_OFF + OFFSET_W;
    localparam int O_TS   = O_SEEN + 1;
    localparam int O_TE   = O_TS + CW;
    localparam int O_EF   = O_TE + CW;
    localparam int O_ET   = O_EF + EW;
    localparam int O_EC   = O_ET + EW;
    localparam bit WIDE_SAMPLE = (SAMPLE_WIDTH >= 64);

    // unpacked item
    t_action               w_act;
    logic [SW-1:0]         w_ffs;
    logic [LEN_W-1:0]      w_len;
    logic [NUM_W-1:0]      w_num;
    logic [SW-1:0]         w_smp;
    logic [FLAG_W-1:0]     w_flg;
    logic [GAIN_IN_W-1:0]  w_g1;
    logic [GAIN_IN_W-1:0]  w_g2;

    logic [FLAG_W-1:0]     r_mask;

    logic [GAIN_W-1:0]     r_sv_gain,  n_sv_gain;
    logic [NUM_W-1:0]      r_sv_next,  n_sv_next;
    logic                  r_sv_nknown, n_sv_nknown;
    logic [SW-1:0]         r_sv_last,  n_sv_last;
    logic                  r_sv_sknown, n_sv_sknown;
    logic [CW-1:0]         r_sv_trans, n_sv_trans;

    logic [GAIN_W-1:0]     r_wk_gain,  n_wk_gain;
    logic [NUM_W-1:0]      r_wk_next,  n_wk_next;
    logic                  r_wk_nknown, n_wk_nknown;
    logic [SW-1:0]         r_wk_last,  n_wk_last;
    logic                  r_wk_sknown, n_wk_sknown;
    logic [CW-1:0]         r_wk_trans, n_wk_trans;

    logic [SW-1:0]         r_win_begin, n_win_begin;
    logic [SW:0]           r_win_end,   n_win_end;
    logic                  r_inside,    n_inside;
    logic                  r_stopped,   n_stopped;
    t_status               r_err,       n_err;
    logic [GAIN_W-1:0]     r_gain_start, n_gain_start;
    logic [CW-1:0]         r_cnt_start,  n_cnt_start;
    logic [EW-1:0]         r_ev_before,  n_ev_before;
    logic [EW-1:0]         r_ev_taken,   n_ev_taken;
    logic [OFFSET_W-1:0]   r_offset,     n_offset;
    logic                  r_offset_set, n_offset_set;

    // event checks against the working copy
    t_status               w_chk;
    logic                  w_changed;
    logic [SW:0]           w_sum;
    logic [SW-1:0]         w_rel;
    logic [GAIN_W-1:0]     w_snap_gain;
    logic [CW-1:0]         w_snap_cnt;
    logic [EW-1:0]         w_snap_before;
    logic                  w_fire;

    assign w_act = t_action'(i_action);
    assign w_ffs = i_data[SW-1:0];
    assign w_len = i_data[LEN_LO +: LEN_W];
    assign w_num = i_data[NUM_LO +: NUM_W];
    assign w_smp = i_data[ES_LO +: SW];
    assign w_flg = i_data[FLG_LO +: FLAG_W];
    assign w_g1  = i_data[G1_LO +: GAIN_IN_W];
    assign w_g2  = i_data[G2_LO +: GAIN_IN_W];

    assign o_take      = i_valid && ((w_act != ACT_END) || i_out_free);
    assign w_fire      = o_take;
    assign o_res_valid = w_fire && (w_act == ACT_END);

    assign w_sum     = {1'b0, w_ffs} + {{(SW + 1 - LEN_W){1'b0}}, w_len};
    assign w_rel     = w_smp - r_win_begin;
    assign w_changed = (w_g1[GAIN_W-1:0] != r_wk_gain);

    always_comb begin
        if ((w_flg & ~r_mask) != '0) begin
            w_chk = ST_FLAGS;
        end else if ((w_g1 > GAIN_MAX) || (w_g1 != w_g2)) begin
            w_chk = ST_GAIN;
        end else if (r_wk_nknown && (w_num != r_wk_next)) begin
            w_chk = ST_SEQ_GAP;
        end else if (r_wk_sknown && (w_smp < r_wk_last)) begin
            w_chk = ST_REGRESS;
        end else if (&r_wk_trans) begin
            w_chk = ST_RANGE;
        end else begin
            w_chk = ST_OK;
        end
    end

    // snapshot values as seen at the frame start
    always_comb begin
        if (r_inside) begin
            w_snap_gain   = r_gain_start;
            w_snap_cnt    = r_cnt_start;
            w_snap_before = r_ev_before;
        end else begin
            w_snap_gain   = r_wk_gain;
            w_snap_cnt    = r_wk_trans;
            w_snap_before = r_ev_taken;
        end
    end

    always_comb begin
        n_sv_gain    = r_sv_gain;
        n_sv_next    = r_sv_next;
        n_sv_nknown  = r_sv_nknown;
        n_sv_last    = r_sv_last;
        n_sv_sknown  = r_sv_sknown;
        n_sv_trans   = r_sv_trans;
        n_wk_gain    = r_wk_gain;
        n_wk_next    = r_wk_next;
        n_wk_nknown  = r_wk_nknown;
        n_wk_last    = r_wk_last;
        n_wk_sknown  = r_wk_sknown;
        n_wk_trans   = r_wk_trans;
        n_win_begin  = r_win_begin;
        n_win_end    = r_win_end;
        n_inside     = r_inside;
        n_stopped    = r_stopped;
        n_err        = r_err;
        n_gain_start = r_gain_start;
        n_cnt_start  = r_cnt_start;
        n_ev_before  = r_ev_before;
        n_ev_taken   = r_ev_taken;
        n_offset     = r_offset;
        n_offset_set = r_offset_set;
        if (w_fire) begin
            unique case (w_act)
                ACT_START: begin
                    n_wk_gain    = r_sv_gain;
                    n_wk_next    = r_sv_next;
                    n_wk_nknown  = r_sv_nknown;
                    n_wk_last    = r_sv_last;
                    n_wk_sknown  = r_sv_sknown;
                    n_wk_trans   = r_sv_trans;
                    n_win_begin  = w_ffs;
                    n_win_end    = w_sum;
                    n_inside     = 1'b0;
                    n_stopped    = 1'b0;
                    n_gain_start = '0;
                    n_cnt_start  = '0;
                    n_ev_before  = '0;
                    n_ev_taken   = '0;
                    n_offset     = '0;
                    n_offset_set = 1'b0;
                    if (w_len == '0) begin
                        n_err = ST_BAD_ARG;
                    end else if (WIDE_SAMPLE && w_sum[SW]) begin
                        n_err = ST_RANGE;
                    end else begin
                        n_err = ST_OK;
                    end
                end
                ACT_EVENT: begin
                    if ((r_err == ST_OK) && !r_stopped) begin
                        if (!r_inside && (w_smp < r_win_begin)) begin
                            if (w_chk != ST_OK) begin
                                n_err = w_chk;
                            end else begin
                                n_wk_gain   = w_g1[GAIN_W-1:0];
                                n_wk_next   = w_num + NUM_W'(1);
                                n_wk_nknown = 1'b1;
                                n_wk_last   = w_smp;
                                n_wk_sknown = 1'b1;
                                n_wk_trans  = r_wk_trans + CW'(1);
                                if (!(&r_ev_taken)) begin
                                    n_ev_taken = r_ev_taken + EW'(1);
                                end
                            end
                        end else begin
                            n_inside     = 1'b1;
                            n_gain_start = w_snap_gain;
                            n_cnt_start  = w_snap_cnt;
                            n_ev_before  = w_snap_before;
                            if ({1'b0, w_smp} >= r_win_end) begin
                                n_stopped = 1'b1;
                            end else if (w_chk != ST_OK) begin
                                n_err = w_chk;
                            end else begin
                                n_wk_gain   = w_g1[GAIN_W-1:0];
                                n_wk_next   = w_num + NUM_W'(1);
                                n_wk_nknown = 1'b1;
                                n_wk_last   = w_smp;
                                n_wk_sknown = 1'b1;
                                n_wk_trans  = r_wk_trans + CW'(1);
                                if (!(&r_ev_taken)) begin
                                    n_ev_taken = r_ev_taken + EW'(1);
                                end
                                if (w_changed && !r_offset_set) begin
                                    n_offset     = w_rel[OFFSET_W-1:0];
                                    n_offset_set = 1'b1;
                                end
                                if (w_smp == r_win_begin) begin
                                    n_gain_start = w_g1[GAIN_W-1:0];
                                end
                            end
                        end
                    end
                end
                ACT_END: begin
                    n_stopped = 1'b1;
                    if (r_err == ST_OK) begin
                        n_inside     = 1'b1;
                        n_gain_start = w_snap_gain;
                        n_cnt_start  = w_snap_cnt;
                        n_ev_before  = w_snap_before;
                        n_sv_gain    = r_wk_gain;
                        n_sv_next    = r_wk_next;
                        n_sv_nknown  = r_wk_nknown;
                        n_sv_last    = r_wk_last;
                        n_sv_sknown  = r_wk_sknown;
                        n_sv_trans   = r_wk_trans;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        o_res_data = '0;
        o_res_data[STATUS_W-1:0] = r_err;
        if (r_err == ST_OK) begin
            o_res_data[O_SG +: GAIN_W]   = w_snap_gain;
            o_res_data[O_EG +: GAIN_W]   = r_wk_gain;
            o_res_data[O_OFF +: OFFSET_W] = r_offset;
            o_res_data[O_SEEN]           = r_offset_set;
            o_res_data[O_TS +: CW]       = w_snap_cnt;
            o_res_data[O_TE +: CW]       = r_wk_trans;
            o_res_data[O_EF +: EW]       = w_snap_before;
            o_res_data[O_ET +: EW]       = r_ev_taken - w_snap_before;
            o_res_data[O_EC +: EW]       = r_ev_taken;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask       <= '0;
            r_sv_gain    <= '0;
            r_sv_next    <= '0;
            r_sv_nknown  <= 1'b0;
            r_sv_last    <= '0;
            r_sv_sknown  <= 1'b0;
            r_sv_trans   <= '0;
            r_wk_gain    <= '0;
            r_wk_next    <= '0;
            r_wk_nknown  <= 1'b0;
            r_wk_last    <= '0;
            r_wk_sknown  <= 1'b0;
            r_wk_trans   <= '0;
            r_win_begin  <= '0;
            r_win_end    <= '0;
            r_inside     <= 1'b0;
            r_stopped    <= 1'b0;
            r_err        <= ST_OK;
            r_gain_start <= '0;
            r_cnt_start  <= '0;
            r_ev_before  <= '0;
            r_ev_taken   <= '0;
            r_offset     <= '0;
            r_offset_set <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            r_sv_gain    <= n_sv_gain;
            r_sv_next    <= n_sv_next;
            r_sv_nknown  <= n_sv_nknown;
            r_sv_last    <= n_sv_last;
            r_sv_sknown  <= n_sv_sknown;
            r_sv_trans   <= n_sv_trans;
            r_wk_gain    <= n_wk_gain;
            r_wk_next    <= n_wk_next;
            r_wk_nknown  <= n_wk_nknown;
            r_wk_last    <= n_wk_last;
            r_wk_sknown  <= n_wk_sknown;
            r_wk_trans   <= n_wk_trans;
            r_win_begin  <= n_win_begin;
            r_win_end    <= n_win_end;
            r_inside     <= n_inside;
            r_stopped    <= n_stopped;
            r_err        <= n_err;
            r_gain_start <= n_gain_start;
            r_cnt_start  <= n_cnt_start;
            r_ev_before  <= n_ev_before;
            r_ev_taken   <= n_ev_taken;
            r_offset     <= n_offset;
            r_offset_set <= n_offset_set;
        end
    end

endmodule

[rtl/core/gevr_out_reg.sv]
// Result register holding one summary until the downstream side takes it.
module gevr_out_reg #(
    parameter int DATA_W = 200
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_free,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_data,
    input  logic              i_ready
);
    import gevr_pkg::*;

    logic              r_valid;
    logic [DATA_W-1:0] r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

[rtl/core/gain_event_timeline_resolver.sv]
// Top level of the gain event timeline resolver.
//
//  channel  | direction | transfer when                  | carries
//  s_axis   | in        | s_axis_tvalid & s_axis_tready  | action in tuser, item in tdata
//  m_axis   | out       | m_axis_tvalid & m_axis_tready  | frame summary in tdata
//  cfg      | in        | i_cfg_we                       | accepted event flag mask
//
// One item per cycle while m_axis does not hold back end items; a summary is valid on m_axis
// once its end item has passed the input register and has been loaded into the result
// register.
// Reset is synchronous, active low, and clears all gain and frame state and the mask.
// A stalled m_axis holds back only end items; start and event items pass freely until
// an end item waits in the input register, which then holds s_axis_tready low.
module gain_event_timeline_resolver #(
    parameter int SAMPLE_WIDTH      = 48,
    parameter int COUNT_WIDTH       = 48,
    parameter int EVENT_COUNT_WIDTH = 16,
    localparam int IN_W  = (((2 * SAMPLE_WIDTH + 88) + 7) / 8) * 8,
    localparam int OUT_W = (((50 + 2 * COUNT_WIDTH + 3 * EVENT_COUNT_WIDTH) + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gevr_pkg::FLAG_W-1:0]   i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // frame_first_sample, frame_length, event_number, event_sample,
    // event_flags, first_gain, second_gain, zero fill
    input  logic [IN_W-1:0]               s_axis_tdata,
    // action
    input  logic [gevr_pkg::ACTION_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status, start_gain, end_gain, change_offset, change_seen,
    // transitions_at_start, transitions_at_end, frame_event_first,
    // frame_event_total, events_consumed, zero fill
    output logic [OUT_W-1:0]              m_axis_tdata
);
    import gevr_pkg::*;

    localparam int O_EF = 50 + 2 * COUNT_WIDTH;
    localparam int O_EC = O_EF + 2 * EVENT_COUNT_WIDTH;
    localparam int O_HI = O_EC + EVENT_COUNT_WIDTH;

    logic                w_in_valid;
    logic [IN_W-1:0]     w_in_data;
    logic [ACTION_W-1:0] w_in_action;
    logic                w_take;
    logic                w_out_free;
    logic                w_res_valid;
    logic [OUT_W-1:0]    w_res_data;

    gevr_in_reg #(
        .DATA_W (IN_W)
    ) u_in_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_action (s_axis_tuser),
        .o_valid  (w_in_valid),
        .o_data   (w_in_data),
        .o_action (w_in_action),
        .i_take   (w_take)
    );

    gevr_core #(
        .SAMPLE_WIDTH      (SAMPLE_WIDTH),
        .COUNT_WIDTH       (COUNT_WIDTH),
        .EVENT_COUNT_WIDTH (EVENT_COUNT_WIDTH),
        .IN_W              (IN_W),
        .OUT_W             (OUT_W)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_in_valid),
        .i_data      (w_in_data),
        .i_action    (w_in_action),
        .i_out_free  (w_out_free),
        .o_take      (w_take),
        .o_res_valid (w_res_valid),
        .o_res_data  (w_res_data)
    );

    gevr_out_reg #(
        .DATA_W (OUT_W)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_res_valid),
        .i_data  (w_res_data),
        .o_free  (w_out_free),
        .o_valid (m_axis_tvalid),
        .o_data  (m_axis_tdata),
        .i_ready (m_axis_tready)
    );

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> (!m_axis_tvalid || m_axis_tready))
        else $error("summary loaded over an untaken result");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_valid && !w_take) |-> !s_axis_tready)
        else $error("input accepted while held item not taken");

    a_error_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[STATUS_W-1:0] != ST_OK))
            |-> (m_axis_tdata[OUT_W-1:STATUS_W] == '0))
        else $error("error summary carries non-zero fields");

    a_counts_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[O_EF +: EVENT_COUNT_WIDTH]
                           <= m_axis_tdata[O_EC +: EVENT_COUNT_WIDTH]))
        else $error("events before frame exceed events consumed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tdata >> O_HI) == '0))
        else $error("result fill bits not zero");

endmodule

[sim/tb.sv]
// Self-checking testbench for gain_event_timeline_resolver: directed table, random frames, scoreboard.
module tb;
    import gevr_pkg::*;

    localparam int SAMPLE_W  = 48;
    localparam int COUNT_W   = 48;
    localparam int EVCNT_W   = 16;
    localparam int IN_W      = 184;
    localparam int OUT_W     = 200;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int N_DIRECTED      = 28;
    localparam int ITEMS_PER_PHASE = 540;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_REPORTS     = 10;
    localparam longint LIMIT_CYCLES = 1000000;

    typedef struct packed {
        logic [GAIN_IN_W-1:0] second_gain;
        logic [GAIN_IN_W-1:0] first_gain;
        logic [FLAG_W-1:0]    event_flags;
        logic [SAMPLE_W-1:0]  event_sample;
        logic [NUM_W-1:0]     event_number;
        logic [LEN_W-1:0]     frame_length;
        logic [SAMPLE_W-1:0]  frame_first_sample;
    } in_bus_t;

    typedef struct packed {
        logic [5:0]          fill;
        logic [EVCNT_W-1:0]  events_consumed;
        logic [EVCNT_W-1:0]  frame_event_total;
        logic [EVCNT_W-1:0]  frame_event_first;
        logic [COUNT_W-1:0]  transitions_at_end;
        logic [COUNT_W-1:0]  transitions_at_start;
        logic                change_seen;
        logic [OFFSET_W-1:0] change_offset;
        logic [GAIN_W-1:0]   end_gain;
        logic [GAIN_W-1:0]   start_gain;
        t_status             status;
    } summary_t;

    typedef struct {
        logic [ACTION_W-1:0] action;
        in_bus_t             data;
        bit                  has_fixed;
        t_status             fixed_status;
    } directed_row_t;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [FLAG_W-1:0]   i_cfg_wdata   = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic [ACTION_W-1:0] s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    gain_event_timeline_resolver i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    // resolver model state
    logic [FLAG_W-1:0]   flag_mask = '0;
    logic [GAIN_W-1:0]   sv_gain = '0, wk_gain = '0, gain_snap = '0;
    logic [NUM_W-1:0]    sv_next = '0, wk_next = '0;
    bit                  sv_num_known, wk_num_known, sv_smp_known, wk_smp_known;
    logic [SAMPLE_W-1:0] sv_last = '0, wk_last = '0, win_begin = '0;
    logic [SAMPLE_W:0]   win_end = '0;
    logic [COUNT_W-1:0]  sv_trans = '0, wk_trans = '0, trans_snap = '0;
    bit                  in_window, stopped, first_off_set;
    t_status             err_latch = ST_OK;
    logic [EVCNT_W-1:0]  ev_before = '0, ev_taken = '0;
    logic [OFFSET_W-1:0] first_off = '0;

    summary_t      summary_q [$];
    directed_row_t directed_rows [N_DIRECTED];
    bit            cur_has_fixed = 1'b0;
    t_status       cur_fixed = ST_OK;
    int            send_idle_pct = 0, recv_idle_pct = 0;
    bit            hold_go = 1'b0;
    int            items_offered = 0, results_checked = 0, starts_seen = 0, mismatches = 0;
    longint        cycles = 0;

    function automatic in_bus_t random_bus();
        return in_bus_t'({$urandom, $urandom, $urandom, $urandom, $urandom, 24'($urandom)});
    endfunction

    function automatic directed_row_t dir_row(
        input logic [ACTION_W-1:0] act, input logic [SAMPLE_W-1:0] first,
        input logic [LEN_W-1:0] len, input logic [NUM_W-1:0] num,
        input logic [SAMPLE_W-1:0] smp, input logic [FLAG_W-1:0] flags,
        input logic [GAIN_IN_W-1:0] g1, input logic [GAIN_IN_W-1:0] g2,
        input bit fixed, input t_status st);
        directed_row_t r;
        r.action                  = act;
        r.data.frame_first_sample = first;
        r.data.frame_length       = len;
        r.data.event_number       = num;
        r.data.event_sample       = smp;
        r.data.event_flags        = flags;
        r.data.first_gain         = g1;
        r.data.second_gain        = g2;
        r.has_fixed               = fixed;
        r.fixed_status            = st;
        return r;
    endfunction

    task automatic take_snapshot();
        in_window  = 1'b1;
        gain_snap  = wk_gain;
        trans_snap = wk_trans;
        ev_before  = ev_taken;
    endtask

    task automatic check_and_apply(input in_bus_t d, output t_status st, output bit changed);
        changed = 1'b0;
        if ((d.event_flags & ~flag_mask) != '0) begin
            st = ST_FLAGS;
        end else if (d.first_gain > GAIN_MAX || d.first_gain != d.second_gain) begin
            st = ST_GAIN;
        end else if (wk_num_known && d.event_number != wk_next) begin
            st = ST_SEQ_GAP;
        end else if (wk_smp_known && d.event_sample < wk_last) begin
            st = ST_REGRESS;
        end else if (wk_trans == '1) begin
            st = ST_RANGE;
        end else begin
            st           = ST_OK;
            changed      = (d.first_gain[GAIN_W-1:0] != wk_gain);
            wk_gain      = d.first_gain[GAIN_W-1:0];
            wk_next      = d.event_number + 32'd1;
            wk_num_known = 1'b1;
            wk_last      = d.event_sample;
            wk_smp_known = 1'b1;
            wk_trans     = wk_trans + 48'd1;
            if (ev_taken != '1) begin
                ev_taken = ev_taken + 16'd1;
            end
        end
    endtask

    task automatic resolve_item(input logic [ACTION_W-1:0] act, input in_bus_t d,
                                output bit produced, output summary_t res);
        t_status st;
        bit      changed;
        res      = '0;
        produced = 1'b0;
        case (act)
            ACT_START: begin
                wk_gain       = sv_gain;
                wk_next       = sv_next;
                wk_num_known  = sv_num_known;
                wk_last       = sv_last;
                wk_smp_known  = sv_smp_known;
                wk_trans      = sv_trans;
                win_begin     = d.frame_first_sample;
                win_end       = {1'b0, d.frame_first_sample} + {17'd0, d.frame_length};
                in_window     = 1'b0;
                stopped       = 1'b0;
                gain_snap     = '0;
                trans_snap    = '0;
                ev_before     = '0;
                ev_taken      = '0;
                first_off     = '0;
                first_off_set = 1'b0;
                err_latch     = (d.frame_length == '0) ? ST_BAD_ARG : ST_OK;
            end
            ACT_EVENT: begin
                if (err_latch == ST_OK && !stopped) begin
                    if (!in_window && d.event_sample < win_begin) begin
                        check_and_apply(d, st, changed);
                        if (st != ST_OK) begin
                            err_latch = st;
                        end
                    end else begin
                        if (!in_window) begin
                            take_snapshot();
                        end
                        if ({1'b0, d.event_sample} >= win_end) begin
                            stopped = 1'b1;
                        end else begin
                            check_and_apply(d, st, changed);
                            if (st != ST_OK) begin
                                err_latch = st;
                            end else begin
                                if (changed && !first_off_set) begin
                                    first_off     = 32'(d.event_sample - win_begin);
                                    first_off_set = 1'b1;
                                end
                                if (d.event_sample == win_begin) begin
                                    gain_snap = wk_gain;
                                end
                            end
                        end
                    end
                end
            end
            ACT_END: begin
                produced = 1'b1;
                stopped  = 1'b1;
                if (err_latch != ST_OK) begin
                    res.status = err_latch;
                end else begin
                    if (!in_window) begin
                        take_snapshot();
                    end
                    res.status               = ST_OK;
                    res.start_gain           = gain_snap;
                    res.end_gain             = wk_gain;
                    res.change_offset        = first_off_set ? first_off : '0;
                    res.change_seen          = first_off_set;
                    res.transitions_at_start = trans_snap;
                    res.transitions_at_end   = wk_trans;
                    res.frame_event_first    = ev_before;
                    res.frame_event_total    = ev_taken - ev_before;
                    res.events_consumed      = ev_taken;
                    sv_gain      = wk_gain;
                    sv_next      = wk_next;
                    sv_num_known = wk_num_known;
                    sv_last      = wk_last;
                    sv_smp_known = wk_smp_known;
                    sv_trans     = wk_trans;
                end
            end
            default: ;
        endcase
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("MISMATCH: %s", msg);
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
        if (got !== want) begin
            note_mismatch($sformatf("summary %0d %s: expected %0h, got %0h",
                                    results_checked, name, want, got));
        end
    endtask

    always @(posedge i_clk) begin
        bit       produced;
        summary_t predicted, got, want, fixed_sum;
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d summaries outstanding.",
                     cycles, summary_q.size());
            $display("** gain_event_timeline_resolver: FAILED **");
            $finish;
        end else if (i_rst_n) begin
            if (i_cfg_we) begin
                flag_mask = i_cfg_wdata;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = summary_t'(m_axis_tdata);
                if (summary_q.size() == 0) begin
                    note_mismatch($sformatf("summary with none outstanding: %h", m_axis_tdata));
                end else begin
                    want = summary_q.pop_front();
                    check_field("status", 64'(got.status), 64'(want.status));
                    check_field("start_gain", 64'(got.start_gain), 64'(want.start_gain));
                    check_field("end_gain", 64'(got.end_gain), 64'(want.end_gain));
                    check_field("change_offset", 64'(got.change_offset),
                                64'(want.change_offset));
                    check_field("change_seen", 64'(got.change_seen), 64'(want.change_seen));
                    check_field("transitions_at_start", 64'(got.transitions_at_start),
                                64'(want.transitions_at_start));
                    check_field("transitions_at_end", 64'(got.transitions_at_end),
                                64'(want.transitions_at_end));
                    check_field("frame_event_first", 64'(got.frame_event_first),
                                64'(want.frame_event_first));
                    check_field("frame_event_total", 64'(got.frame_event_total),
                                64'(want.frame_event_total));
                    check_field("events_consumed", 64'(got.events_consumed),
                                64'(want.events_consumed));
                    results_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == ACT_START) begin
                    starts_seen++;
                end
                resolve_item(s_axis_tuser, in_bus_t'(s_axis_tdata), produced, predicted);
                if (produced) begin
                    if (cur_has_fixed) begin
                        fixed_sum        = '0;
                        fixed_sum.status = cur_fixed;
                        summary_q.push_back(fixed_sum);
                    end else begin
                        summary_q.push_back(predicted);
                    end
                end
            end
        end
    end

    initial begin
        int  hold_left;
        bit  hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic offer_item(input logic [ACTION_W-1:0] act, input in_bus_t data,
                              input bit has_fixed, input t_status fixed_status);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= data;
        cur_has_fixed <= has_fixed;
        cur_fixed     <= fixed_status;
        do @(posedge i_clk); while (!s_axis_tready);
        items_offered++;
    endtask

    task automatic wait_drained(input int extra);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (summary_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (extra) @(negedge i_clk);
    endtask

    task automatic write_flag_mask(input logic [FLAG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic run_random_frames(input int target);
        int                  stop_at, r;
        in_bus_t             d;
        logic [SAMPLE_W-1:0] frame_begin, smp;
        logic [NUM_W-1:0]    num;
        logic [GAIN_W-1:0]   gain;
        stop_at = items_offered + target;
        while (items_offered < stop_at) begin
            d = random_bus();
            if ($urandom_range(99) < 6) begin
                offer_item(2'($urandom), d, 1'b0, ST_OK);
            end else begin
                if ($urandom_range(19) == 0) begin
                    frame_begin = d.frame_first_sample;
                end else begin
                    frame_begin = wk_last + SAMPLE_W'($urandom_range(40));
                end
                r = $urandom_range(19);
                if (r == 0) begin
                    d.frame_length = '0;
                end else if (r == 1) begin
                    d.frame_length = 32'd1;
                end else if (r > 3) begin
                    d.frame_length = $urandom_range(60, 1);
                end
                d.frame_first_sample = frame_begin;
                offer_item(ACT_START, d, 1'b0, ST_OK);
                num  = wk_num_known ? wk_next : $urandom;
                smp  = wk_smp_known ? wk_last : frame_begin - SAMPLE_W'($urandom_range(20));
                gain = wk_gain;
                repeat ($urandom_range(10)) begin
                    d = random_bus();
                    r = $urandom_range(99);
                    if (r < 4) begin
                        smp = smp - SAMPLE_W'($urandom_range(5, 1));
                    end else if (r < 12 && smp < frame_begin) begin
                        smp = frame_begin;
                    end else begin
                        smp = smp + SAMPLE_W'($urandom_range(15));
                    end
                    if ($urandom_range(99) < 60) begin
                        gain = GAIN_W'($urandom);
                    end
                    d.event_sample = smp;
                    d.event_number = ($urandom_range(99) < 5) ? $urandom : num;
                    if ($urandom_range(99) >= 4) begin
                        d.event_flags = d.event_flags & flag_mask;
                    end
                    r = $urandom_range(99);
                    if (r == 3) begin
                        d.second_gain = d.first_gain;
                    end else if (r > 3) begin
                        d.first_gain  = {1'b0, gain};
                        d.second_gain = {1'b0, gain};
                    end
                    offer_item(ACT_EVENT, d, 1'b0, ST_OK);
                    num = num + 32'd1;
                end
                offer_item(ACT_END, random_bus(), 1'b0, ST_OK);
                if ($urandom_range(99) < 8) begin
                    offer_item(ACT_END, random_bus(), 1'b0, ST_OK);
                end
                if ($urandom_range(99) < 5) begin
                    offer_item(ACT_EVENT, random_bus(), 1'b0, ST_OK);
                end
            end
        end
    endtask

    initial begin
        logic [FLAG_W-1:0]   mid_mask;

        directed_rows = '{
            dir_row(ACT_EVENT, '0, '0, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_OK),
            dir_row(ACT_UNUSED, '1, '1, '1, '1, '1, '1, '1, 1'b0, ST_OK),
            dir_row(ACT_START, '0, '0, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, '0, 48'd5, '0, 8'd1, 8'd1, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_BAD_ARG),
            dir_row(ACT_START, '1, '1, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, '0, '1, 8'h80, 8'd5, 8'd5, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_FLAGS),
            dir_row(ACT_START, 48'd1000, 32'd100, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, '0, 48'd10, '0, 8'h80, 8'h80, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_GAIN),
            dir_row(ACT_START, 48'd1000, 32'd100, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, '0, 48'd10, '0, 8'd3, 8'd4, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_GAIN),
            dir_row(ACT_START, 48'd1000, 32'd100, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, '1, 48'd10, '0, 8'd127, 8'd127, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, '0, 48'd1000, '0, 8'd127, 8'd127, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, 32'd1, 48'd1050, '0, 8'd0, 8'd0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, 32'd2, 48'd1100, '0, 8'd9, 8'd9, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_START, 48'd2000, 32'd10, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, 32'd5, 48'd2005, '0, 8'd0, 8'd0, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_SEQ_GAP),
            dir_row(ACT_START, 48'd2000, 32'd10, '0, '0, '0, '0, '0, 1'b0, ST_OK),
            dir_row(ACT_EVENT, '0, '0, 32'd2, 48'd1049, '0, 8'd0, 8'd0, 1'b0, ST_OK),
            dir_row(ACT_END, '0, '0, '0, '0, '0, '0, '0, 1'b1, ST_REGRESS)
        };

        send_idle_pct = 15;
        recv_idle_pct = 85;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].action, directed_rows[i].data,
                       directed_rows[i].has_fixed, directed_rows[i].fixed_status);
        end

        wait_drained(DRAIN_CYCLES);
        write_flag_mask(8'hFF);
        run_random_frames(ITEMS_PER_PHASE);

        wait_drained(DRAIN_CYCLES);
        mid_mask = 8'($urandom);
        write_flag_mask(mid_mask);
        send_idle_pct = 85;
        recv_idle_pct = 15;
        run_random_frames(ITEMS_PER_PHASE);

        wait_drained(DRAIN_CYCLES);
        write_flag_mask(8'h00);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_go       = 1'b1;
        run_random_frames(ITEMS_PER_PHASE);

        wait_drained(2 * DRAIN_CYCLES);
        $display("Covered %0d input transfers, %0d summaries checked, %0d frame starts.",
                 items_offered, results_checked, starts_seen);
        $display("Flag masks 00, FF and %02h; %0d-cycle output hold-off with input pressure.",
                 mid_mask, HOLD_CYCLES);
        if (mismatches == 0 && summary_q.size() == 0) begin
            $display("** gain_event_timeline_resolver: PASSED **");
        end else begin
            $display("** gain_event_timeline_resolver: FAILED **");
        end
        $finish;
    end

endmodule
